/* src/dsnt_pkg.sv */
// Shared constants, seed table and subtract-stage functions for the square-root unit.
package dsnt_pkg;

  localparam int NEWTON_STEPS_DEF = 6;
  localparam int MUL_LAT  = 3;
  localparam int SUB_LAT  = 3;
  localparam int STEP_LAT = 3 * MUL_LAT + SUB_LAT;

  localparam logic [31:0] EXP_OFFSET = 32'h1FF8_0000;
  localparam logic [10:0] EXP_SCALE_ODD  = 11'h3FF;
  localparam logic [10:0] EXP_SCALE_EVEN = 11'h400;
  localparam logic [10:0] EXP_THREE      = 11'h400;
  localparam logic [63:0] HALF_EXP_DEC   = 64'h0010_0000_0000_0000;

  typedef logic [63:0] dbl_t;

  function automatic dbl_t seed_lookup(input logic [2:0] idx);
    dbl_t s;
    case (idx)
      3'd0: s = 64'h3fe56936540bcb0d;
      3'd1: s = 64'h3fe35800415a86d3;
      3'd2: s = 64'h3fe1c80dd9ac3519;
      3'd3: s = 64'h3fe08be934f91569;
      3'd4: s = 64'h3fee47948f3386d8;
      3'd5: s = 64'h3feb5b289ea02719;
      3'd6: s = 64'h3fe92589e4ff9edc;
      3'd7: s = 64'h3fe766721c52539d;
      default: s = '0;
    endcase
    return s;
  endfunction

  // 3.0 - x on a 56-bit grid (53 mantissa bits plus guard, round, sticky)
  function automatic logic [55:0] sub_align(input dbl_t x);
    logic [11:0] d;
    logic [55:0] full;
    logic [55:0] shf;
    logic [55:0] mask;
    logic        sticky;
    logic [55:0] a3;
    d    = {1'b0, EXP_THREE - x[62:52]};
    full = {1'b1, x[51:0], 3'b000};
    a3   = {2'b11, 51'd0, 3'b000};
    if (d >= 12'd56) begin
      shf    = '0;
      sticky = 1'b1;
    end else begin
      shf    = full >> d[5:0];
      mask   = ~({56{1'b1}} << d[5:0]);
      sticky = |(full & mask);
    end
    return a3 - (shf | {55'd0, sticky});
  endfunction

  function automatic logic [5:0] lzc56(input logic [55:0] v);
    logic [5:0] n;
    logic       found;
    n     = '0;
    found = 1'b0;
    for (int i = 55; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) begin
          found = 1'b1;
        end else begin
          n = n + 6'd1;
        end
      end
    end
    return n;
  endfunction

  function automatic dbl_t sub_round(input logic [55:0] dv, input logic [5:0] lz);
    logic [55:0] nv;
    logic [52:0] mant;
    logic        up;
    logic [53:0] mr;
    logic [10:0] e;
    logic [51:0] frac;
    nv   = dv << lz;
    mant = nv[55:3];
    up   = nv[2] & (nv[1] | nv[0] | mant[0]);
    mr   = {1'b0, mant} + {53'd0, up};
    e    = EXP_THREE - {5'd0, lz};
    if (mr[53]) begin
      e    = e + 11'd1;
      frac = mr[52:1];
    end else begin
      frac = mr[51:0];
    end
    return {1'b0, e, frac};
  endfunction

endpackage

/* src/double_sqrt_newton_table_unit.sv */
// Top level of the pipelined double square-root unit.
// Usage:
//   Input channel: value_bits_i carries raw double bits, taken when in_valid_i
//   is high and in_stall_o is low. Output channel: root_bits_o carries raw
//   result bits, handed off when out_valid_o is high and out_stall_i is low.
//   Each Newton step spends three multiplier passes and one subtract
//   stage; after the last step come a final multiply and the output
//   register.
//   Throughput is one word per cycle while the output is not stalled; every
//   stage is a full register stage and words do not interact.
//   Reset clears all valid bits; no word is in flight afterwards.
//   While a waiting result is stalled the whole pipeline holds and in_stall_o
//   is raised; nothing is lost or repeated, and it resumes on release.
//   Operands are not screened: zero, negative, denormal, infinite and NaN
//   inputs go through the same fixed formula.
module double_sqrt_newton_table_unit
  import dsnt_pkg::*;
#(
  parameter int NEWTON_STEPS = NEWTON_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] root_bits_o
);

  localparam int EXP_DLY  = STEP_LAT * NEWTON_STEPS + MUL_LAT;
  localparam int PIPE_LAT = EXP_DLY + 1;

  logic                en;
  logic [PIPE_LAT-1:0] v_q;
  logic [31:0]         hi;
  logic [31:0]         expo_sum;
  logic [11:0]         exp_dly_q [EXP_DLY];
  dbl_t                y_s [NEWTON_STEPS+1];
  dbl_t                a_s [NEWTON_STEPS+1];
  dbl_t                r;
  dbl_t                root_d, root_q;

  assign en         = !(v_q[PIPE_LAT-1] && out_stall_i);
  assign in_stall_o = !en;

  assign hi       = value_bits_i[63:32];
  assign expo_sum = {1'b0, hi[31:1]} + EXP_OFFSET;
  assign y_s[0]   = {1'b0, hi[20] ? EXP_SCALE_ODD : EXP_SCALE_EVEN, hi[19:0],
                     value_bits_i[31:0]};
  assign a_s[0]   = seed_lookup(hi[20:18]);

  for (genvar g = 0; g < NEWTON_STEPS; g++) begin : gen_step
    dbl_t        ya, yaa;
    dbl_t        a_dly_q    [MUL_LAT];
    dbl_t        half_dly_q [2*MUL_LAT+SUB_LAT];
    dbl_t        y_dly_q    [STEP_LAT];
    logic [55:0] sub1_q, sub2_q;
    logic [5:0]  lz_q;
    dbl_t        diff_q;

    dsnt_mul u_ya (.clk_i, .en_i(en), .a_i(y_s[g]), .b_i(a_s[g]), .p_o(ya));
    dsnt_mul u_yaa (.clk_i, .en_i(en), .a_i(ya), .b_i(a_dly_q[MUL_LAT-1]), .p_o(yaa));
    dsnt_mul u_new (.clk_i, .en_i(en), .a_i(half_dly_q[2*MUL_LAT+SUB_LAT-1]),
                    .b_i(diff_q), .p_o(a_s[g+1]));

    always_ff @(posedge clk_i) begin
      if (en) begin
        a_dly_q[0]    <= a_s[g];
        half_dly_q[0] <= a_s[g] - HALF_EXP_DEC;
        y_dly_q[0]    <= y_s[g];
        for (int i = 1; i < MUL_LAT; i++) a_dly_q[i] <= a_dly_q[i-1];
        for (int i = 1; i < 2*MUL_LAT+SUB_LAT; i++) half_dly_q[i] <= half_dly_q[i-1];
        for (int i = 1; i < STEP_LAT; i++) y_dly_q[i] <= y_dly_q[i-1];
        sub1_q <= sub_align(yaa);
        sub2_q <= sub1_q;
        lz_q   <= lzc56(sub1_q);
        diff_q <= sub_round(sub2_q, lz_q);
      end
    end

    assign y_s[g+1] = y_dly_q[STEP_LAT-1];
  end

  dsnt_mul u_root (.clk_i, .en_i(en), .a_i(a_s[NEWTON_STEPS]), .b_i(y_s[NEWTON_STEPS]),
                   .p_o(r));

  assign root_d = {exp_dly_q[EXP_DLY-1], r[51:0]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      exp_dly_q[0] <= expo_sum[31:20];
      for (int i = 1; i < EXP_DLY; i++) exp_dly_q[i] <= exp_dly_q[i-1];
      root_q <= root_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  assign out_valid_o = v_q[PIPE_LAT-1];
  assign root_bits_o = root_q;

endmodule

/* src/dsnt_mul.sv */
// Three-stage double multiplier for positive normal operands, round to nearest even.
module dsnt_mul
  import dsnt_pkg::*;
(
  input  logic clk_i,
  input  logic en_i,
  input  dbl_t a_i,
  input  dbl_t b_i,
  output dbl_t p_o
);

  logic [52:0]  ma, mb;
  logic [51:0]  hh_d, hh_q;
  logic [52:0]  hl_d, hl_q, lh_d, lh_q;
  logic [53:0]  ll_d, ll_q;
  logic [11:0]  e1_d, e1_q, e2_q;
  logic [53:0]  mid;
  logic [105:0] p_d, p_q;
  logic [52:0]  mant;
  logic         up;
  logic [53:0]  mr;
  logic [10:0]  e;
  logic [51:0]  frac;
  dbl_t         r_d, r_q;

  assign ma   = {1'b1, a_i[51:0]};
  assign mb   = {1'b1, b_i[51:0]};
  assign hh_d = 52'(ma[52:27]) * 52'(mb[52:27]);
  assign hl_d = 53'(ma[52:27]) * 53'(mb[26:0]);
  assign lh_d = 53'(ma[26:0]) * 53'(mb[52:27]);
  assign ll_d = 54'(ma[26:0]) * 54'(mb[26:0]);
  assign e1_d = {1'b0, a_i[62:52]} + {1'b0, b_i[62:52]} - 12'd1023;

  assign mid = 54'(hl_q) + 54'(lh_q);
  assign p_d = {hh_q, 54'd0} + (106'(mid) << 27) + 106'(ll_q);

  always_comb begin
    e = e2_q[10:0];
    if (p_q[105]) begin
      mant = p_q[105:53];
      up   = p_q[52] & ((|p_q[51:0]) | p_q[53]);
      e    = e + 11'd1;
    end else begin
      mant = p_q[104:52];
      up   = p_q[51] & ((|p_q[50:0]) | p_q[52]);
    end
    mr = {1'b0, mant} + {53'd0, up};
    if (mr[53]) begin
      e    = e + 11'd1;
      frac = mr[52:1];
    end else begin
      frac = mr[51:0];
    end
    r_d = {1'b0, e, frac};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= hh_d;
      hl_q <= hl_d;
      lh_q <= lh_d;
      ll_q <= ll_d;
      e1_q <= e1_d;
      p_q  <= p_d;
      e2_q <= e1_q;
      r_q  <= r_d;
    end
  end

  assign p_o = r_q;

endmodule

/* sim/testbench.sv */
// Testbench for the double square-root unit: random and corner operands, self-checking.
module testbench
  import dsnt_pkg::*;
();

  typedef enum int {CHK_MATCH, CHK_MISMATCH, CHK_EMPTY} chk_e;

  class root_scoreboard;
    logic [63:0] expected_roots[$];
    logic [63:0] seeds[8];

    function new();
      seeds = '{64'h3fe56936540bcb0d, 64'h3fe35800415a86d3,
                64'h3fe1c80dd9ac3519, 64'h3fe08be934f91569,
                64'h3fee47948f3386d8, 64'h3feb5b289ea02719,
                64'h3fe92589e4ff9edc, 64'h3fe766721c52539d};
    endfunction

    function logic [63:0] predict_root(logic [63:0] v);
      logic [31:0] hi;
      logic [31:0] expo;
      logic [31:0] scaled_hi;
      logic [63:0] rb;
      real y;
      real a;
      real half;
      real yaa;
      real r;
      hi = v[63:32];
      expo = ((hi >> 1) + 32'h1FF8_0000) & 32'hFFF0_0000;
      scaled_hi = (hi & 32'h000F_FFFF) + 32'h4000_0000 - (hi & 32'h0010_0000);
      y = $bitstoreal({scaled_hi, v[31:0]});
      a = $bitstoreal(seeds[scaled_hi[20:18]]);
      for (int k = 0; k < NEWTON_STEPS_DEF; k++) begin
        half = 0.5 * a;
        yaa = (y * a) * a;
        a = half * (3.0 - yaa);
      end
      r = a * y;
      rb = $realtobits(r);
      return {(rb[63:32] & 32'h000F_FFFF) | expo, rb[31:0]};
    endfunction

    function void note_operand(logic [63:0] v);
      expected_roots.push_back(predict_root(v));
    endfunction

    function chk_e check_root(logic [63:0] got, output logic [63:0] want);
      want = '0;
      if (expected_roots.size() == 0) return CHK_EMPTY;
      want = expected_roots.pop_front();
      return (want === got) ? CHK_MATCH : CHK_MISMATCH;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] value_bits_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] root_bits_o;

  root_scoreboard sb = new();
  logic [63:0] operands[$];
  int errors = 0;
  int accepted = 0;
  bit sender_done = 0;

  double_sqrt_newton_table_unit i_dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    $display("mismatch: %s expected %h got %h", what, want, got);
    errors++;
  endtask

  function automatic logic [63:0] random_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(3) != 0) v[62:52] = 11'($urandom_range(11'h7FE, 1));
    return v;
  endfunction

  task automatic send_words();
    int gap;
    int burst;
    gap = 0;
    burst = $urandom_range(20, 1);
    while (operands.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) begin
        sb.note_operand(value_bits_i);
        accepted++;
      end
      if (in_valid_i && in_stall_o) continue;
      if (gap > 0) begin
        gap--;
        in_valid_i <= 1'b0;
      end else if (operands.size() != 0) begin
        value_bits_i <= operands.pop_front();
        in_valid_i <= 1'b1;
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(30, 1);
          gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    sender_done = 1;
  endtask

  // result side
  initial begin
    logic [63:0] want;
    chk_e st;
    int hold;
    bit long_done;
    hold = 0;
    long_done = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        st = sb.check_root(root_bits_o, want);
        if (st == CHK_EMPTY) report("unexpected word", '0, root_bits_o);
        else if (st == CHK_MISMATCH) report("root_bits", want, root_bits_o);
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (!long_done && accepted > 300) begin
        long_done = 1;
        hold = 400;
        out_stall_i <= 1'b1;
      end else if (accepted > 900 && accepted < 1100) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(3) == 0);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 200000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    operands = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000,
                 64'h4000_0000_0000_0000, 64'h4010_0000_0000_0000,
                 64'hC000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                 64'h7FF8_0000_0000_0001, 64'h0000_0000_0000_0001,
                 64'h000F_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000,
                 64'h7FEF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                 64'h3FF4_0000_0000_0000, 64'h3FF8_0000_0000_0000,
                 64'h3FFC_0000_0000_0000, 64'h3FFF_FFFF_FFFF_FFFF,
                 64'h4004_0000_0000_0000, 64'h4008_0000_0000_0000,
                 64'h400C_0000_0000_0000, 64'h400F_FFFF_FFFF_FFFF,
                 64'h4022_0000_0000_0000, 64'h5555_5555_5555_5555,
                 64'hAAAA_AAAA_AAAA_AAAA};
    for (int i = 0; i < 1400; i++) operands.push_back(random_operand());
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_words();
    wait (sb.expected_roots.size() == 0);
    repeat (100) @(posedge clk_i);
    if (sb.expected_roots.size() != 0) report("leftover word", sb.expected_roots[0], '0);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* double_sqrt_newton_table_unit.f */
src/dsnt_pkg.sv
src/dsnt_mul.sv
src/double_sqrt_newton_table_unit.sv
sim/testbench.sv
